// ----- sv/assert_macros.svh -----
// assertion macros for the rtl of the box blur unit
// needs nothing but a clock and an active-low reset at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/bblur_pkg.sv -----
// types, constants and the reciprocal table of the 3x3 rgb box blur unit
// self-contained, used by box_blur_3x3_rgb_unit
`default_nettype none

package bblur_pkg;

	// frame geometry
	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EFF_W_W      = $clog2(MAX_WIDTH + 1);
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 16;
	localparam int ROW_W        = HEIGHT_REG_W + 1;

	// configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

	localparam logic MODE_PIXEL = 1'b0;

	typedef logic [COL_W-1:0]        col_t;
	typedef logic [EFF_W_W-1:0]      wid_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [HEIGHT_REG_W-1:0] hgt_t;

	localparam wid_t WIDTH_RESET  = wid_t'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
	localparam hgt_t HEIGHT_RESET = hgt_t'(768);

	// datapath widths
	localparam int CHANNELS    = 3;
	localparam int CH_W        = 8;
	localparam int COL_SUM_W   = CH_W + 2;
	localparam int SUM_W       = CH_W + 4;
	localparam int NUM_W       = SUM_W + 1;
	localparam int COUNT_W     = 4;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// channel 2 red, 1 green, 0 blue
	typedef logic [CHANNELS-1:0][CH_W-1:0] rgb_t;

	typedef struct packed {
		logic            mode;
		logic [CH_W-1:0] pixel_red;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] blurred_red;
		logic [CH_W-1:0] blurred_green;
		logic [CH_W-1:0] blurred_blue;
		logic            frame_end;
	} pix_out_t;

	// which neighbours of the output pixel lie in the frame
	typedef struct packed {
		logic top_in;
		logic bot_in;
		logic left_in;
		logic right_in;
		logic frame_end;
	} ctrl_t;

	// ceil(2^RECIP_SHIFT / (2*count)), exact for numerators below 2^13
	function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		unique case (count)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- sv/box_blur_3x3_rgb_unit.sv -----
// 3x3 rgb box blur, edge averaged, one pixel request per clock while results are taken, raster order
// path: a request emitting a result passes stages 1 to 5 and shows on res from the stage 5 output register
// throughput: one request per cycle sustained while res_ready holds, through the five-stage pipeline
// and line stores that are read and written in the same cycle, written once per request
// reset: arst_n clears counters and valid bits, width 1024, height 768
// depends on bblur_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module box_blur_3x3_rgb_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 pix_valid,
	output logic                                      pix_ready,
	input  wire bblur_pkg::pix_in_t                   pix,

	output logic                                      res_valid,
	input  wire logic                                 res_ready,
	output bblur_pkg::pix_out_t                       res,

	input  wire logic                                 cfg_we,
	input  wire bblur_pkg::cfg_idx_t                  cfg_index,
	input  wire logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// ------------------------------------------------------------------
	// configuration, stored already clamped to the usable range
	// ------------------------------------------------------------------
	bblur_pkg::wid_t width_q;
	bblur_pkg::hgt_t height_q;
	bblur_pkg::wid_t width_cfg;
	bblur_pkg::hgt_t height_cfg;
	logic [31:0]     wval;

	always_comb begin
		wval = 32'(cfg_data[bblur_pkg::WIDTH_REG_W-1:0]);
		if (wval == 32'd0) begin
			wval = 32'd1;
		end else if (wval > 32'(bblur_pkg::MAX_WIDTH)) begin
			wval = 32'(bblur_pkg::MAX_WIDTH);
		end
		width_cfg  = wval[bblur_pkg::EFF_W_W-1:0];
		height_cfg = (cfg_data[bblur_pkg::HEIGHT_REG_W-1:0] == '0) ?
			bblur_pkg::hgt_t'(1) : cfg_data[bblur_pkg::HEIGHT_REG_W-1:0];
	end

	// ------------------------------------------------------------------
	// stage enables, each stage moves when empty or when the next moves
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic acc;

	assign en_s5     = !v_s5 || res_ready;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pix_ready = en_s1;
	assign acc       = pix_valid && pix_ready;

	// ------------------------------------------------------------------
	// input position counters and emission decode
	// ------------------------------------------------------------------
	// row_q runs up to height+1: rows past the frame are drain rows
	bblur_pkg::row_t  row_q;
	bblur_pkg::col_t  col_q;
	bblur_pkg::row_t  h_ext;
	bblur_pkg::row_t  row_limit;
	logic             drain;
	logic             active;
	logic             col_zero;
	logic             row_end_case;
	logic             inner_case;
	logic             emit;
	bblur_pkg::ctrl_t ctrl;
	bblur_pkg::rgb_t  in_rgb;
	bblur_pkg::wid_t  col_inc;
	logic             wrap;

	always_comb begin
		h_ext     = bblur_pkg::row_t'(height_q);
		row_limit = h_ext + bblur_pkg::row_t'(1);
		drain     = row_q >= h_ext;
		// a drain request while the frame still arrives is dropped
		active    = drain || (pix.mode == bblur_pkg::MODE_PIXEL);
		col_zero  = col_q == '0;
		// column zero closes the row two above: its last pixel comes out
		row_end_case = col_zero && (row_q >= bblur_pkg::row_t'(2));
		// otherwise the pixel one row up and one column left comes out
		inner_case   = !col_zero && (row_q != '0);
		emit         = row_end_case || inner_case;

		ctrl = '0;
		if (row_end_case) begin
			ctrl.top_in    = row_q != bblur_pkg::row_t'(2);
			ctrl.bot_in    = (row_q - bblur_pkg::row_t'(1)) < h_ext;
			ctrl.left_in   = width_q != bblur_pkg::wid_t'(1);
			ctrl.right_in  = 1'b0;
			// last column of the last row ends the frame
			ctrl.frame_end = !((row_q - bblur_pkg::row_t'(1)) < h_ext);
		end else begin
			ctrl.top_in    = row_q != bblur_pkg::row_t'(1);
			ctrl.bot_in    = row_q < h_ext;
			ctrl.left_in   = col_q != bblur_pkg::col_t'(1);
			ctrl.right_in  = 1'b1;
			ctrl.frame_end = 1'b0;
		end

		// drain rows push black pixels, never seen in any sum
		in_rgb = drain ? '0 : {pix.pixel_red, pix.pixel_green, pix.pixel_blue};

		col_inc = bblur_pkg::wid_t'(col_q) + bblur_pkg::wid_t'(1);
		wrap    = col_inc >= width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bblur_pkg::WIDTH_RESET;
			height_q <= bblur_pkg::HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_we) begin
			// any write abandons the frame in progress
			unique case (cfg_index)
				bblur_pkg::REG_IMAGE_WIDTH:  width_q  <= width_cfg;
				bblur_pkg::REG_IMAGE_HEIGHT: height_q <= height_cfg;
				default:                     width_q  <= width_q;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (acc && active) begin
			if (ctrl.frame_end && emit) begin
				row_q <= '0;
				col_q <= '0;
			end else if (wrap) begin
				row_q <= row_q + bblur_pkg::row_t'(1);
				col_q <= '0;
			end else begin
				col_q <= bblur_pkg::col_t'(col_inc);
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: line store read, forwarding, write back and window shift
	// ------------------------------------------------------------------
	bblur_pkg::rgb_t  upper_mem  [bblur_pkg::MAX_WIDTH];
	bblur_pkg::rgb_t  middle_mem [bblur_pkg::MAX_WIDTH];
	bblur_pkg::rgb_t  up_rd_s1, mid_rd_s1;
	bblur_pkg::rgb_t  fwd_up_s1, fwd_mid_s1;
	logic             fwd_s1;
	bblur_pkg::col_t  addr_s1;
	bblur_pkg::rgb_t  pixel_s1;
	logic             emit_s1;
	bblur_pkg::ctrl_t ctrl_s1;
	bblur_pkg::rgb_t  above_col, mid_col;
	logic             wr_en;

	// the leaving request writes back as the next one reads
	assign wr_en = v_s1 && en_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[addr_s1]  <= mid_col;
			middle_mem[addr_s1] <= pixel_s1;
		end
		if (en_s1) begin
			up_rd_s1  <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
		end
	end

	// same column back to back (one pixel wide frames): bypass the store
	always_ff @(posedge clk) begin
		if (en_s1) begin
			fwd_s1     <= wr_en && (addr_s1 == col_q);
			fwd_up_s1  <= mid_col;
			fwd_mid_s1 <= pixel_s1;
			addr_s1    <= col_q;
			pixel_s1   <= in_rgb;
			emit_s1    <= emit;
			ctrl_s1    <= ctrl;
		end
	end

	assign above_col = fwd_s1 ? fwd_up_s1  : up_rd_s1;
	assign mid_col   = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	// window row 0 is the row above the output pixel, column 1 its column
	bblur_pkg::rgb_t window_q [3][3];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < 3; k++) begin
				window_q[k][0] <= window_q[k][1];
				window_q[k][1] <= window_q[k][2];
			end
			window_q[0][2] <= above_col;
			window_q[1][2] <= mid_col;
			window_q[2][2] <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: masked column sums from the window
	// ------------------------------------------------------------------
	bblur_pkg::ctrl_t ctrl_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	logic [bblur_pkg::COL_SUM_W-1:0] col_sum [bblur_pkg::CHANNELS][3];
	logic [1:0]                      rows_in, cols_in;
	logic [bblur_pkg::COUNT_W-1:0]   count_s2;
	logic                            col_on [3];

	always_comb begin
		col_on[0] = ctrl_s2.left_in;
		col_on[1] = 1'b1;
		col_on[2] = ctrl_s2.right_in;
		for (int ch = 0; ch < bblur_pkg::CHANNELS; ch++) begin
			for (int j = 0; j < 3; j++) begin
				col_sum[ch][j] =
					(ctrl_s2.top_in ? bblur_pkg::COL_SUM_W'(window_q[0][j][ch]) : '0) +
					bblur_pkg::COL_SUM_W'(window_q[1][j][ch]) +
					(ctrl_s2.bot_in ? bblur_pkg::COL_SUM_W'(window_q[2][j][ch]) : '0);
				if (!col_on[j]) begin
					col_sum[ch][j] = '0;
				end
			end
		end
		rows_in  = 2'd1 + {1'b0, ctrl_s2.top_in} + {1'b0, ctrl_s2.bot_in};
		cols_in  = 2'd1 + {1'b0, ctrl_s2.left_in} + {1'b0, ctrl_s2.right_in};
		count_s2 = bblur_pkg::COUNT_W'(rows_in) * bblur_pkg::COUNT_W'(cols_in);
	end

	// ------------------------------------------------------------------
	// stage 3: total and rounding numerator 2*sum + count
	// ------------------------------------------------------------------
	logic [bblur_pkg::COL_SUM_W-1:0] col_sum_s3 [bblur_pkg::CHANNELS][3];
	logic [bblur_pkg::COUNT_W-1:0]   count_s3;
	logic                            end_s3;
	logic [bblur_pkg::SUM_W-1:0]     total [bblur_pkg::CHANNELS];
	logic [bblur_pkg::NUM_W-1:0]     num   [bblur_pkg::CHANNELS];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			col_sum_s3 <= col_sum;
			count_s3   <= count_s2;
			end_s3     <= ctrl_s2.frame_end;
		end
	end

	always_comb begin
		for (int ch = 0; ch < bblur_pkg::CHANNELS; ch++) begin
			total[ch] = bblur_pkg::SUM_W'(col_sum_s3[ch][0]) +
				bblur_pkg::SUM_W'(col_sum_s3[ch][1]) +
				bblur_pkg::SUM_W'(col_sum_s3[ch][2]);
			num[ch] = {total[ch], 1'b0} + bblur_pkg::NUM_W'(count_s3);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: divide by 2*count as a multiply by its reciprocal
	// ------------------------------------------------------------------
	logic [bblur_pkg::NUM_W-1:0]   num_s4 [bblur_pkg::CHANNELS];
	logic [bblur_pkg::RECIP_W-1:0] recip_s4;
	logic                          end_s4;
	logic [bblur_pkg::PROD_W-1:0]  prod  [bblur_pkg::CHANNELS];
	bblur_pkg::rgb_t               mean;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			num_s4   <= num;
			recip_s4 <= bblur_pkg::recip_of(count_s3);
			end_s4   <= end_s3;
		end
	end

	always_comb begin
		for (int ch = 0; ch < bblur_pkg::CHANNELS; ch++) begin
			prod[ch] = bblur_pkg::PROD_W'(num_s4[ch]) * bblur_pkg::PROD_W'(recip_s4);
			mean[ch] = prod[ch][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
		end
	end

	// ------------------------------------------------------------------
	// stage 5: output register
	// ------------------------------------------------------------------
	bblur_pkg::pix_out_t res_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			res_s5.blurred_red   <= mean[2];
			res_s5.blurred_green <= mean[1];
			res_s5.blurred_blue  <= mean[0];
			res_s5.frame_end     <= end_s4;
		end
	end

	assign res       = res_s5;
	assign res_valid = v_s5;

	// valid bits, only requests that emit go past stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= acc && active && !cfg_we;
			end
			if (en_s2) begin
				v_s2 <= v_s1 && emit_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`ASSERT_ALWAYS(a_col_in_row, clk, arst_n, bblur_pkg::wid_t'(col_q) < width_q, "column counter past row width")
	`ASSERT_ALWAYS(a_row_bound, clk, arst_n, row_q <= row_limit, "row counter past drain rows")
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !pix_ready, res_valid && !res_ready, "input stalled without output back pressure")

endmodule

`default_nettype wire

// ----- tb/blur_checker.sv -----
`timescale 1ns / 1ps
// scoreboard of the 3x3 rgb box blur unit: watches the pixel, result and register ports,
// keeps its own copy of line stores, window and counters, and checks each blurred pixel
// depends on bblur_pkg
module blur_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	input  logic                              pix_ready,
	input  bblur_pkg::pix_in_t                pix,
	input  logic                              res_valid,
	input  logic                              res_ready,
	input  bblur_pkg::pix_out_t               res,
	input  logic                              cfg_we,
	input  bblur_pkg::cfg_idx_t               cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                mismatches,
	output int                                pending,
	output int                                results_seen,
	output int                                frames_seen
);
	import bblur_pkg::*;

	typedef logic [3*CH_W-1:0] rgb24_t;

	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	rgb24_t                  upper_line [MAX_WIDTH];
	rgb24_t                  middle_line [MAX_WIDTH];
	rgb24_t                  win [3][3];
	int unsigned             at_row;
	int unsigned             at_col;
	pix_out_t                blurred_due [$];

	function automatic int unsigned frame_cols();
		int unsigned w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	// rounded mean over the in-frame part of the window, centre in column cc
	function automatic pix_out_t window_mean(input int cc, input int unsigned orow,
			input int unsigned ocol, input int unsigned w, input int unsigned h);
		int unsigned sum [3];
		int unsigned cnt;
		int          wc;
		rgb24_t      px;
		pix_out_t    o;
		sum = '{0, 0, 0};
		cnt = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			if (dr < 0 && orow == 0) continue;
			if (dr > 0 && orow + 1 >= h) continue;
			for (int dc = -1; dc <= 1; dc++) begin
				if (dc < 0 && ocol == 0) continue;
				if (dc > 0 && ocol + 1 >= w) continue;
				wc = cc + dc;
				if (wc < 0 || wc > 2) continue;
				px = win[dr + 1][wc];
				sum[0] += px[3*CH_W-1:2*CH_W];
				sum[1] += px[2*CH_W-1:CH_W];
				sum[2] += px[CH_W-1:0];
				cnt++;
			end
		end
		o.blurred_red   = CH_W'((2 * sum[0] + cnt) / (2 * cnt));
		o.blurred_green = CH_W'((2 * sum[1] + cnt) / (2 * cnt));
		o.blurred_blue  = CH_W'((2 * sum[2] + cnt) / (2 * cnt));
		o.frame_end     = 1'b0;
		return o;
	endfunction

	// one accepted request: shift stores and window, queue the pixel it releases
	function automatic void advance_blur(input pix_in_t item);
		int unsigned w, h, r, c, orow, ocol;
		rgb24_t      pixel, above, mid;
		pix_out_t    o;
		bit          emitted;
		w = frame_cols();
		h = (height_reg == 0) ? 1 : height_reg;
		r = at_row;
		c = at_col;
		orow = 0;
		ocol = 0;
		emitted = 1'b0;
		if (r < h) begin
			if (item.mode != MODE_PIXEL) return;
			pixel = {item.pixel_red, item.pixel_green, item.pixel_blue};
		end else begin
			pixel = '0;
		end
		if (c >= MAX_WIDTH) c = 0;
		// last pixel of the row two rows up
		if (c == 0 && r >= 2) begin
			orow = r - 2;
			ocol = w - 1;
			o = window_mean(2, orow, ocol, w, h);
			emitted = 1'b1;
		end
		above = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = pixel;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = above;
		win[1][2] = mid;
		win[2][2] = pixel;
		if (c >= 1 && r >= 1) begin
			orow = r - 1;
			ocol = c - 1;
			o = window_mean(1, orow, ocol, w, h);
			emitted = 1'b1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		at_row = r;
		at_col = c;
		if (!emitted) return;
		if (orow + 1 >= h && ocol + 1 >= w) begin
			o.frame_end = 1'b1;
			at_row = 0;
			at_col = 0;
		end
		blurred_due.push_back(o);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
			at_row = 0;
			at_col = 0;
			blurred_due.delete();
			mismatches = 0;
			results_seen = 0;
			frames_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[WIDTH_REG_W-1:0];
				else height_reg = cfg_data[HEIGHT_REG_W-1:0];
				at_row = 0;
				at_col = 0;
			end
			if (pix_valid && pix_ready) advance_blur(pix);
			if (res_valid && res_ready) begin
				if (blurred_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t blur: result with none due: r %0d g %0d b %0d end %0b",
							$time, res.blurred_red, res.blurred_green, res.blurred_blue,
							res.frame_end);
				end else begin
					want = blurred_due.pop_front();
					if (res.blurred_red !== want.blurred_red ||
							res.blurred_green !== want.blurred_green ||
							res.blurred_blue !== want.blurred_blue ||
							res.frame_end !== want.frame_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t blur mismatch: want r %0d g %0d b %0d end %0b, got r %0d g %0d b %0d end %0b",
								$time, want.blurred_red, want.blurred_green,
								want.blurred_blue, want.frame_end, res.blurred_red,
								res.blurred_green, res.blurred_blue, res.frame_end);
					end
					results_seen++;
					if (want.frame_end) frames_seen++;
				end
			end
			pending = blurred_due.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// top of the box blur testbench: clock, reset, pixel and register stimulus, result stalls
// depends on bblur_pkg, box_blur_3x3_rgb_unit and blur_checker
module tb_top;
	import bblur_pkg::*;

	localparam logic MODE_DRAIN = 1'b1;
	// cycles to wait past the last expected result, well beyond the pipeline depth
	localparam int SETTLE = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_in_t               pix = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	pix_out_t              res;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches, pending, results_seen, frames_seen;

	// idle rates in percent, and the long receiver hold-off
	int src_idle = 9;
	int sink_idle = 64;
	int hold_span = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;

	int items_sent = 0;
	int cfg_writes = 0;

	always #2 clk = ~clk;

	box_blur_3x3_rgb_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blur_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pix          (pix),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.frames_seen  (frames_seen)
	);

	// result side: random stalls, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (holds_asked != holds_done) begin
			holds_done = holds_asked;
			hold_left = hold_span;
		end
		if (hold_left > 0) begin
			res_ready <= 1'b0;
			hold_left--;
		end else begin
			res_ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// channel value, biased toward the extremes
	function automatic logic [CH_W-1:0] rand_chan();
		logic [CH_W-1:0] v;
		case ($urandom_range(3))
			0: v = '0;
			1: v = '1;
			default: v = CH_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic pix_in_t make_px(input logic mode, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		pix_in_t p;
		p.mode = mode;
		p.pixel_red = r;
		p.pixel_green = g;
		p.pixel_blue = b;
		return p;
	endfunction

	function automatic pix_in_t rand_px(input logic mode);
		return make_px(mode, rand_chan(), rand_chan(), rand_chan());
	endfunction

	// offer one request, with random idle cycles first; returns just after the accepting edge
	task automatic send_px(input pix_in_t item);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix <= item;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
	endtask

	// drop valid so the last request is not taken twice
	task automatic hold_input();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	// nothing due and the pipeline empty, also of requests that release no pixel
	task automatic settle();
		hold_input();
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// raw register values; upper data bits of the width write carry junk
	task automatic set_frame(input int raw_w, input int raw_h);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[WIDTH_REG_W-1:0] = WIDTH_REG_W'(raw_w);
		write_reg(REG_IMAGE_WIDTH, d);
		write_reg(REG_IMAGE_HEIGHT, HEIGHT_REG_W'(raw_h));
	endtask

	// one frame of w x h pixels plus drains; a tidy frame gets exactly w+1 drains,
	// otherwise drains may run short or long, or the frame is cut halfway
	task automatic run_frame(input int w, input int h, input bit tidy, output bit cut);
		int   total, pause_at, drains, style;
		logic dmode;
		total = w * h;
		style = tidy ? 7 : $urandom_range(7);
		pause_at = ($urandom_range(4) == 0) ? int'($urandom_range(total - 1)) : -1;
		cut = 1'b0;
		for (int i = 0; i < total; i++) begin
			if (style == 2 && i > 0 && i == total / 2) begin
				cut = 1'b1;
				return;
			end
			// sender waits mid-frame until every released pixel is out
			if (i == pause_at) begin
				hold_input();
				wait (pending == 0);
			end
			// drain tick while the frame arrives, ignored by the unit
			if ($urandom_range(19) == 0) send_px(rand_px(MODE_DRAIN));
			send_px(rand_px(MODE_PIXEL));
			items_sent++;
		end
		drains = w + 1;
		if (style == 0) drains = $urandom_range(w);
		else if (style == 1) drains += $urandom_range(1, 3);
		for (int i = 0; i < drains; i++) begin
			// a pixel past the end of the frame counts as a drain
			dmode = ($urandom_range(7) == 0) ? MODE_PIXEL : MODE_DRAIN;
			send_px(rand_px(dmode));
			items_sent++;
		end
	endtask

	// frames of random small sizes until the budget of requests is spent
	task automatic random_frames(input int budget);
		int start, raw_w, raw_h, cur_w, cur_h;
		bit cut, wide;
		start = items_sent;
		cut = 1'b1;
		cur_w = 1;
		cur_h = 1;
		while (items_sent - start < budget) begin
			// a cut frame is abandoned by the next register write
			if (cut || $urandom_range(2) == 0) begin
				wide = ($urandom_range(9) == 0);
				raw_w = wide ? $urandom_range(30, 200) : $urandom_range(0, 12);
				raw_h = wide ? $urandom_range(0, 2) : $urandom_range(0, 7);
				set_frame(raw_w, raw_h);
				cur_w = (raw_w == 0) ? 1 : raw_w;
				cur_h = (raw_h == 0) ? 1 : raw_h;
			end
			run_frame(cur_w, cur_h, 1'b0, cut);
		end
	endtask

	initial begin
		bit cut;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset geometry 1024 x 768: enough rows to release the first few pixels
		repeat (MAX_WIDTH + 8) begin
			send_px(rand_px(MODE_PIXEL));
			items_sent++;
		end

		// 3x3 frame, red and green alternating full and empty, blue a ramp: corners, edges, centre
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_px(make_px(MODE_DRAIN, '1, '1, '1));
			send_px(make_px(MODE_PIXEL, (i % 2) ? 8'd0 : 8'd255, (i % 2) ? 8'd255 : 8'd0,
				CH_W'(i * 31)));
		end
		repeat (3) send_px(make_px(MODE_DRAIN, '0, '0, '0));
		send_px(make_px(MODE_PIXEL, '1, '1, '1));
		// single pixel frame, then zero width and height taken as one
		set_frame(1, 1);
		send_px(make_px(MODE_PIXEL, '1, '1, '1));
		repeat (2) send_px(make_px(MODE_DRAIN, '0, '0, '0));
		set_frame(0, 0);
		send_px(make_px(MODE_PIXEL, 8'd1, 8'd254, 8'd128));
		repeat (2) send_px(make_px(MODE_DRAIN, '1, '1, '1));
		// one pixel wide column
		set_frame(1, 3);
		send_px(make_px(MODE_PIXEL, '1, '0, '1));
		send_px(make_px(MODE_PIXEL, '0, '1, '0));
		send_px(make_px(MODE_PIXEL, '1, '1, '0));
		repeat (2) send_px(make_px(MODE_DRAIN, '0, '0, '0));
		items_sent += 25;

		// widest register value saturates to the full line width
		set_frame(2047, 1);
		run_frame(MAX_WIDTH, 1, 1'b1, cut);
		// tallest frame, abandoned after a few rows
		set_frame(2, 65535);
		repeat (20) begin
			send_px(rand_px(MODE_PIXEL));
			items_sent++;
		end
		set_frame(MAX_WIDTH, 2);
		run_frame(MAX_WIDTH, 2, 1'b1, cut);

		random_frames(700);

		// sender idles most, receiver stalls rarely
		settle();
		src_idle = 64;
		sink_idle = 9;
		random_frames(650);

		// no idling; a long result hold-off fills the unit and stalls its input
		settle();
		src_idle = 0;
		sink_idle = 0;
		set_frame(10, 8);
		hold_span = 400;
		holds_asked++;
		run_frame(10, 8, 1'b1, cut);
		random_frames(650);

		settle();
		$display("covered %0d requests, %0d blurred pixels checked over %0d finished frames",
			items_sent, results_seen, frames_seen);
		$display("%0d register writes, widths 0..2047 and heights 0..65535, %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
